/* design/lcs_pkg.sv */
package lcs_pkg;

    // field widths
    localparam int RAW_W   = 32;
    localparam int PIX_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int BIAS_W  = 40;
    localparam int PT_W    = 32;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 40;

    // datapath widths
    localparam int X_W     = 17;               // scaled input, signed
    localparam int PROD_W  = GAIN_W + X_W;     // gain * x, signed
    localparam int Q_W     = PROD_W - FRAC_W;  // integer part of gain * x + bias
    localparam int DEN_W   = 32;               // white - black, and v - black
    localparam int QUO_W   = PIX_W;            // quotient bits
    localparam int NUM_W   = DEN_W + QUO_W;    // (v - black) * range
    localparam int DIV_STEPS = QUO_W;          // one quotient bit per stage

    // guarded int mode limit
    localparam logic signed [RAW_W-1:0] GUARD_LIMIT = 32'sd16777215;

    typedef enum logic [1:0] {
        MODE_BYTE      = 2'd0,
        MODE_S16       = 2'd1,
        MODE_INT_GUARD = 2'd2,
        MODE_INT_RAW   = 2'd3
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 4'd0,
        REG_GAIN  = 4'd1,
        REG_BIAS  = 4'd2,
        REG_BLACK = 4'd3,
        REG_WHITE = 4'd4,
        REG_OMIN  = 4'd5,
        REG_OMAX  = 4'd6,
        REG_RANGE = 4'd7
    } t_reg_idx;

    // which output a pixel takes after the black / white tests
    typedef enum logic [1:0] {
        SEL_MIN = 2'd0,
        SEL_MAX = 2'd1,
        SEL_DIV = 2'd2
    } t_sel;

    typedef struct packed {
        t_mode                      mode;
        logic signed [GAIN_W-1:0]   gain;
        logic signed [BIAS_W-1:0]   bias;
        logic signed [PT_W-1:0]     black_point;
        logic signed [PT_W-1:0]     white_point;
        logic [PIX_W-1:0]           out_min;
        logic [PIX_W-1:0]           out_max;
        logic [PIX_W-1:0]           display_range;
    } t_cfg;

    typedef struct packed {
        logic signed [RAW_W-1:0]    raw_pixel;
        logic                       frame_end;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0]           shown_pixel;
        logic                       frame_end_out;
    } t_pix_out;

    // front end to divider
    typedef struct packed {
        logic                       valid;
        t_sel                       sel;
        logic                       byte_mode;
        logic                       frame_end;
        logic [NUM_W-1:0]           num;
        logic [DEN_W-1:0]           den;
    } t_div_in;

endpackage

/* design/lcs_regs.sv */
module lcs_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [lcs_pkg::IDX_W-1:0]   i_wr_index,
    input  logic [lcs_pkg::DATA_W-1:0]  i_wr_data,
    output lcs_pkg::t_cfg               o_cfg
);
    import lcs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_S16;
            r_cfg.gain          <= 32'sd65536;
            r_cfg.bias          <= '0;
            r_cfg.black_point   <= '0;
            r_cfg.white_point   <= 32'sd65535;
            r_cfg.out_min       <= '0;
            r_cfg.out_max       <= '1;
            r_cfg.display_range <= '1;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_MODE:  r_cfg.mode          <= t_mode'(i_wr_data[1:0]);
                REG_GAIN:  r_cfg.gain          <= $signed(i_wr_data[GAIN_W-1:0]);
                REG_BIAS:  r_cfg.bias          <= $signed(i_wr_data[BIAS_W-1:0]);
                REG_BLACK: r_cfg.black_point   <= $signed(i_wr_data[PT_W-1:0]);
                REG_WHITE: r_cfg.white_point   <= $signed(i_wr_data[PT_W-1:0]);
                REG_OMIN:  r_cfg.out_min       <= i_wr_data[PIX_W-1:0];
                REG_OMAX:  r_cfg.out_max       <= i_wr_data[PIX_W-1:0];
                REG_RANGE: r_cfg.display_range <= i_wr_data[PIX_W-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/lcs_front.sv */
module lcs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lcs_pkg::t_pix_in    i_pixel,
    input  lcs_pkg::t_cfg       i_cfg,
    output lcs_pkg::t_div_in    o_stage
);
    import lcs_pkg::*;

    localparam logic signed [Q_W-1:0] BYTE_MAX = 33'sd255;
    localparam logic signed [Q_W-1:0] S16_MIN  = -33'sd32768;
    localparam logic signed [Q_W-1:0] S16_MAX  = 33'sd32767;

    // stage a: gain multiply, int path
    logic signed [X_W-1:0]    n_x;
    logic signed [PROD_W-1:0] n_a_prod;
    logic [PIX_W-1:0]         n_a_intv;
    logic                     r_a_valid;
    logic                     r_a_fe;
    t_mode                    r_a_mode;
    logic signed [PROD_W-1:0] r_a_prod;
    logic [PIX_W-1:0]         r_a_intv;

    // stage b: bias, truncate, saturate
    logic signed [PROD_W-1:0] n_b_sum;
    logic [Q_W-1:0]           n_b_q;
    logic [PIX_W-1:0]         n_b_v;
    logic                     r_b_valid;
    logic                     r_b_fe;
    logic                     r_b_byte;
    logic [PIX_W-1:0]         r_b_v;

    // stage c: black / white tests
    logic signed [PT_W:0]     n_c_v;
    logic signed [PT_W:0]     n_c_blk;
    logic signed [PT_W:0]     n_c_wht;
    logic [PT_W:0]            n_c_diff;
    logic [PT_W:0]            n_c_span;
    t_sel                     n_c_sel;
    logic                     r_c_valid;
    logic                     r_c_fe;
    logic                     r_c_byte;
    t_sel                     r_c_sel;
    logic [DEN_W-1:0]         r_c_diff;
    logic [DEN_W-1:0]         r_c_den;

    // stage d: range multiply
    t_div_in                  r_d;

    always_comb begin
        case (i_cfg.mode)
            MODE_BYTE: n_x = $signed({{(X_W-8){1'b0}}, i_pixel.raw_pixel[7:0]});
            default:   n_x = $signed({i_pixel.raw_pixel[15], i_pixel.raw_pixel[15:0]});
        endcase
        n_a_prod = $signed({{(PROD_W-GAIN_W){i_cfg.gain[GAIN_W-1]}}, i_cfg.gain})
                 * $signed({{(PROD_W-X_W){n_x[X_W-1]}}, n_x});
        if (i_cfg.mode == MODE_INT_GUARD && i_pixel.raw_pixel > GUARD_LIMIT) begin
            n_a_intv = i_cfg.out_max;
        end else begin
            n_a_intv = i_pixel.raw_pixel[PIX_W-1:0];
        end
    end

    always_comb begin
        n_b_sum = r_a_prod
                + $signed({{(PROD_W-BIAS_W){i_cfg.bias[BIAS_W-1]}}, i_cfg.bias});
        // shift then step back toward zero for negative values with a fraction
        n_b_q = n_b_sum[PROD_W-1:FRAC_W]
              + Q_W'(n_b_sum[PROD_W-1] && (n_b_sum[FRAC_W-1:0] != '0));
        case (r_a_mode)
            MODE_BYTE: begin
                if ($signed(n_b_q) < 0) begin
                    n_b_v = '0;
                end else if ($signed(n_b_q) > BYTE_MAX) begin
                    n_b_v = PIX_W'(8'hff);
                end else begin
                    n_b_v = {8'd0, n_b_q[7:0]};
                end
            end
            MODE_S16: begin
                if ($signed(n_b_q) < S16_MIN) begin
                    n_b_v = 16'h8000;
                end else if ($signed(n_b_q) > S16_MAX) begin
                    n_b_v = 16'h7fff;
                end else begin
                    n_b_v = n_b_q[PIX_W-1:0];
                end
            end
            default: n_b_v = r_a_intv;
        endcase
    end

    always_comb begin
        n_c_v    = $signed({{(PT_W+1-PIX_W){1'b0}}, r_b_v});
        n_c_blk  = $signed({i_cfg.black_point[PT_W-1], i_cfg.black_point});
        n_c_wht  = $signed({i_cfg.white_point[PT_W-1], i_cfg.white_point});
        n_c_diff = n_c_v - n_c_blk;
        n_c_span = n_c_wht - n_c_blk;
        if (n_c_v <= n_c_blk) begin
            n_c_sel = SEL_MIN;
        end else if (n_c_v >= n_c_wht) begin
            n_c_sel = SEL_MAX;
        end else begin
            n_c_sel = SEL_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d.valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d.valid <= r_c_valid;
        end
        r_a_fe    <= i_pixel.frame_end;
        r_a_mode  <= i_cfg.mode;
        r_a_prod  <= n_a_prod;
        r_a_intv  <= n_a_intv;

        r_b_fe    <= r_a_fe;
        r_b_byte  <= (r_a_mode == MODE_BYTE);
        r_b_v     <= n_b_v;

        r_c_fe    <= r_b_fe;
        r_c_byte  <= r_b_byte;
        r_c_sel   <= n_c_sel;
        // both fit 32 unsigned bits whenever the divide path is taken
        r_c_diff  <= n_c_diff[DEN_W-1:0];
        r_c_den   <= n_c_span[DEN_W-1:0];

        r_d.sel       <= r_c_sel;
        r_d.byte_mode <= r_c_byte;
        r_d.frame_end <= r_c_fe;
        r_d.num       <= NUM_W'(r_c_diff) * NUM_W'(i_cfg.display_range);
        r_d.den       <= r_c_den;
    end

    assign o_stage = r_d;

endmodule

/* design/lcs_div.sv */
module lcs_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcs_pkg::t_cfg       i_cfg,
    input  lcs_pkg::t_div_in    i_stage,
    output logic                o_strobe,
    output lcs_pkg::t_pix_out   o_result
);
    import lcs_pkg::*;

    typedef struct packed {
        logic               valid;
        t_sel               sel;
        logic               byte_mode;
        logic               frame_end;
        logic [DEN_W-1:0]   rem;
        logic [QUO_W-1:0]   low;
        logic [QUO_W-1:0]   quo;
        logic [DEN_W-1:0]   den;
    } t_dstage;

    // one restoring step: bring down the next numerator bit
    function automatic t_dstage div_step(input t_dstage s);
        t_dstage          r;
        logic [DEN_W:0]   trial;
        r     = s;
        trial = {s.rem, s.low[QUO_W-1]};
        if (trial >= {1'b0, s.den}) begin
            r.rem = DEN_W'(trial - {1'b0, s.den});
            r.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[DEN_W-1:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        r.low = {s.low[QUO_W-2:0], 1'b0};
        return r;
    endfunction

    t_dstage          n_src;
    t_dstage          n_st [DIV_STEPS];
    t_dstage          r_st [DIV_STEPS];
    t_dstage          w_last;
    logic [PIX_W-1:0] n_pix;
    logic             r_strobe;
    t_pix_out         r_result;

    always_comb begin
        n_src.valid     = i_stage.valid;
        n_src.sel       = i_stage.sel;
        n_src.byte_mode = i_stage.byte_mode;
        n_src.frame_end = i_stage.frame_end;
        n_src.rem       = i_stage.num[NUM_W-1:QUO_W];
        n_src.low       = i_stage.num[QUO_W-1:0];
        n_src.quo       = '0;
        n_src.den       = i_stage.den;
        n_st[0] = div_step(n_src);
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_st[k] = div_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_st[k].valid <= 1'b0;
            end
        end else begin
            r_st <= n_st;
        end
    end

    assign w_last = r_st[DIV_STEPS-1];

    always_comb begin
        case (w_last.sel)
            SEL_MIN: n_pix = i_cfg.out_min;
            SEL_MAX: n_pix = i_cfg.out_max;
            default: n_pix = w_last.quo;
        endcase
        if (w_last.byte_mode && n_pix > PIX_W'(8'hff)) begin
            n_pix = PIX_W'(8'hff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_last.valid;
        end
        r_result.shown_pixel   <= n_pix;
        r_result.frame_end_out <= w_last.frame_end;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // quotient fits 16 bits: top of numerator below divisor on entry
    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_stage.valid && i_stage.sel == SEL_DIV)
        |-> (i_stage.num[NUM_W-1:QUO_W] < i_stage.den))
        else $error("divider entry numerator too large");

    // remainder is below divisor at the end of the chain
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last.valid && w_last.sel == SEL_DIV) |-> (w_last.rem < w_last.den))
        else $error("divider remainder out of range");

    // every strobe traces back to a word entering the divider
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_stage.valid, DIV_STEPS + 1))
        else $error("result strobe without matching entry");

endmodule

/* design/pixel_linear_contrast_stretch_top.sv */
// an accepted pixel passes through the pipeline registers before its result strobe
// (4 front stages, 16 divider stages, 1 output register)
// throughput: one pixel per clock; busy is a registered copy of reset
// the divider is a chain of 16 restoring stages, one quotient bit each
// synchronous active-low reset clears all valid bits and reloads register defaults
// results cannot be held off by the receiver, so there is no backpressure path
module pixel_linear_contrast_stretch_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel command channel
    input  logic                        start,
    output logic                        busy,
    input  lcs_pkg::t_pix_in            i_pixel,
    // result channel, one-cycle strobe
    output logic                        o_strobe,
    output lcs_pkg::t_pix_out           o_result,
    // register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lcs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lcs_pkg::DATA_W-1:0]  i_cfg_data
);
    import lcs_pkg::*;

    // held high through reset so nothing is taken while the pipe clears
    logic     r_in_rst;
    logic     w_accept;
    logic     w_cfg_wr;
    t_cfg     w_cfg;
    t_div_in  w_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rst <= 1'b1;
        end else begin
            r_in_rst <= 1'b0;
        end
    end

    // the pipe never stalls, so a pixel word can enter every cycle outside reset
    assign busy        = r_in_rst;
    assign w_accept    = start && !r_in_rst;

    // register writes are taken any time outside reset
    assign o_cfg_ready = !r_in_rst;
    assign w_cfg_wr    = i_cfg_valid && !r_in_rst;

    // register file, indices above the list are ignored
    lcs_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_cfg_wr),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // front end: gain multiply, bias and saturation, black / white tests,
    // range multiply; valid bits ride alongside the data
    lcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pixel    (i_pixel),
        .i_cfg      (w_cfg),
        .o_stage    (w_stage)
    );

    // pipelined divide and final output select, byte mode clamp to 255
    lcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_stage    (w_stage),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
